// ----- rtl/core/ffha_pkg.sv -----
// Package for the first-fit heap allocator: sizes, status codes and the
// segment record layout. Used by first_fit_heap_allocator_unit.
`default_nettype none
package ffha_pkg;
   localparam int MaxSegments = 64;
   localparam int IdxW        = $clog2(MaxSegments);
   localparam int CntW        = IdxW + 1;
   localparam int HeaderBytes = 12;
   localparam int AlignBytes  = 4;
   localparam int SplitSlack  = 16;
   localparam int SegW        = 65;

   localparam logic [31:0] BaseReset  = 32'h0010_0000;
   localparam logic [31:0] LimitReset = 32'h0020_0000;
   localparam logic [31:0] SizeReset  = LimitReset - BaseReset - 32'(HeaderBytes);

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ZERO    = 3'd1,
      ST_OOM     = 3'd2,
      ST_NULL    = 3'd3,
      ST_UNKNOWN = 3'd4
   } status_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [0:0] REG_BASE  = 1'b0;
   localparam logic [0:0] REG_LIMIT = 1'b1;

   typedef struct packed {
      logic [31:0] offset;
      logic [31:0] size;
      logic        free;
   } seg_type;
endpackage
`default_nettype wire

// ----- rtl/core/ffha_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ffha_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/first_fit_heap_allocator_unit.sv -----
// Top level of the first-fit heap allocator: APB registers, command
// sequencer and the segment table RAM. Depends on ffha_pkg and ffha_ram.
`default_nettype none
// The segment table lives in one RAM of MaxSegments entries that is read
// and written one entry a cycle. A command scans the table from entry 0,
// visiting the entries in order, and its result beat is registered from
// S_DONE once the scan and any split or merge are over; a failed command
// scans every live entry. A split then moves the tail up one entry at a
// time through S_SHUP and S_SHUPW, and writes the remainder entry in
// S_SHUP and the granted entry in S_SHUPW. After its hit a free looks at
// the next entry in S_MERGE, and each forward merge moves the tail down
// one entry at a time through S_SHDNW and S_SHDN. A command takes longest
// when many adjacent free segments merge. No new command is taken until
// the result beat has been accepted. Reset and any register write set the
// table to one free segment.
module first_fit_heap_allocator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [31:0] req_request_bytes,
   input  wire logic [31:0] req_free_address,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [31:0] rsp_result_address,
   output logic      [2:0]  rsp_status,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import ffha_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SCAN   = 8'b0000_0010,
      S_SHUP   = 8'b0000_0100,
      S_SHUPW  = 8'b0000_1000,
      S_MERGE  = 8'b0001_0000,
      S_SHDN   = 8'b0010_0000,
      S_SHDNW  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] base_ff, base_in, limit_ff, limit_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;   // scan index / entry of interest
   logic [CntW-1:0] mv_ff, mv_in;     // shift index
   logic        cmd_ff, cmd_in;
   logic [32:0] need_ff, need_in;
   logic [31:0] addr_ff, addr_in;
   seg_type     hit_ff, hit_in;       // entry being granted or freed
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [2:0]  rsp_st_ff, rsp_st_in;

   logic            wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   seg_type         wr_data, rd_data;
   logic [SegW-1:0] rd_raw;

   ffha_ram #(.Width(SegW), .Depth(MaxSegments)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );
   assign rd_data = rd_raw;

   logic cfg_wr;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         REG_BASE:  csr_prdata = base_ff;
         REG_LIMIT: csr_prdata = limit_ff;
         default:   csr_prdata = base_ff;
      endcase
   end

   logic [32:0] span;
   logic [31:0] seg0_size;
   always_comb begin
      span = (limit_in >= base_in) ? ({1'b0, limit_in} - {1'b0, base_in}) : 33'd0;
      seg0_size = (span >= 33'(HeaderBytes)) ? 32'(span - 33'(HeaderBytes)) : 32'd0;
   end

   seg_type    cur;
   logic [31:0] pay;
   logic [34:0] split_need;
   logic [32:0] merged;
   assign req_ready = (state_ff == S_IDLE) && !(rsp_valid_ff && !rsp_ready) && !cfg_wr;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_st_ff;

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      limit_in = limit_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      mv_in = mv_ff;
      cmd_in = cmd_ff;
      need_in = need_ff;
      addr_in = addr_ff;
      hit_in = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in = rsp_addr_ff;
      rsp_st_in = rsp_st_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff[IdxW-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[IdxW-1:0];
      cur = rd_data;
      pay = base_ff + cur.offset + 32'(HeaderBytes);
      split_need = {2'b0, need_ff} + 35'(HeaderBytes) + 35'(SplitSlack);
      merged = {1'b0, hit_ff.size} + 33'(HeaderBytes) + {1'b0, cur.size};

      if (reset) begin
         wr_en = 1'b1;
         wr_addr = '0;
         wr_data = '{offset: 32'd0, size: SizeReset, free: 1'b1};
      end else if (cfg_wr) begin
         if (csr_paddr[2] == REG_BASE) base_in = csr_pwdata;
         else limit_in = csr_pwdata;
         wr_en = 1'b1;
         wr_addr = '0;
         wr_data = '{offset: 32'd0, size: seg0_size, free: 1'b1};
         count_in = CntW'(1);
      end else begin
         priority case (state_ff)
            S_IDLE: begin
               rd_addr = '0;
               if (req_valid && req_ready) begin
                  cmd_in = req_command;
                  need_in = ({1'b0, req_request_bytes} + 33'(AlignBytes - 1))
                            & ~33'(AlignBytes - 1);
                  addr_in = req_free_address;
                  idx_in = '0;
                  if (req_command == CMD_ALLOC && req_request_bytes == 32'd0) begin
                     rsp_st_in = ST_ZERO; rsp_addr_in = '0; state_in = S_DONE;
                  end else if (req_command == CMD_FREE && req_free_address == 32'd0) begin
                     rsp_st_in = ST_NULL; rsp_addr_in = '0; state_in = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // rd_data holds entry idx_ff.
               rd_addr = IdxW'(idx_ff + CntW'(1));
               if (idx_ff >= count_ff) begin
                  rsp_addr_in = '0;
                  rsp_st_in = (cmd_ff == CMD_ALLOC) ? ST_OOM : ST_UNKNOWN;
                  state_in = S_DONE;
               end else if (cmd_ff == CMD_ALLOC) begin
                  if (cur.free && {1'b0, cur.size} >= need_ff) begin
                     rsp_addr_in = pay; rsp_st_in = ST_OK;
                     if ({3'b0, cur.size} >= split_need && count_ff < CntW'(MaxSegments)) begin
                        hit_in = cur;
                        mv_in = count_ff;
                        rd_addr = IdxW'(count_ff - CntW'(1));
                        state_in = S_SHUP;
                     end else begin
                        wr_en = 1'b1;
                        wr_data = '{offset: cur.offset, size: cur.size, free: 1'b0};
                        state_in = S_DONE;
                     end
                  end else begin
                     idx_in = idx_ff + CntW'(1);
                  end
               end else begin
                  if (pay == addr_ff) begin
                     rsp_addr_in = '0; rsp_st_in = ST_OK;
                     hit_in = '{offset: cur.offset, size: cur.size, free: 1'b1};
                     state_in = S_MERGE;
                  end else begin
                     idx_in = idx_ff + CntW'(1);
                  end
               end
            end
            S_SHUP: begin
               // mv_ff is destination; rd_data is entry mv_ff-1 (read last cycle).
               if (mv_ff > idx_ff + CntW'(1)) begin
                  wr_en = 1'b1;
                  wr_addr = mv_ff[IdxW-1:0];
                  wr_data = rd_data;
                  mv_in = mv_ff - CntW'(1);
                  rd_addr = IdxW'(mv_ff - CntW'(2));
                  state_in = S_SHUPW;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = IdxW'(idx_ff + CntW'(1));
                  wr_data = '{offset: hit_ff.offset + 32'(HeaderBytes) + need_ff[31:0],
                              size: hit_ff.size - need_ff[31:0] - 32'(HeaderBytes),
                              free: 1'b1};
                  state_in = S_SHUPW;
                  mv_in = '0;
               end
            end
            S_SHUPW: begin
               rd_addr = IdxW'(mv_ff - CntW'(1));
               if (mv_ff == '0) begin
                  wr_en = 1'b1;
                  wr_data = '{offset: hit_ff.offset, size: need_ff[31:0], free: 1'b0};
                  count_in = count_ff + CntW'(1);
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHUP;
               end
            end
            S_MERGE: begin
               // rd_data is entry idx_ff+1.
               rd_addr = IdxW'(idx_ff + CntW'(2));
               if (idx_ff + CntW'(1) < count_ff && cur.free) begin
                  hit_in.size = merged[31:0];
                  mv_in = idx_ff + CntW'(1);
                  state_in = S_SHDNW;
               end else begin
                  wr_en = 1'b1;
                  wr_data = hit_ff;
                  state_in = S_DONE;
               end
            end
            S_SHDNW: begin
               // rd_data is entry mv_ff+1 once read; this state waits for the read.
               rd_addr = IdxW'(mv_ff + CntW'(1));
               state_in = S_SHDN;
            end
            S_SHDN: begin
               if (mv_ff + CntW'(1) < count_ff) begin
                  wr_en = 1'b1;
                  wr_addr = mv_ff[IdxW-1:0];
                  wr_data = rd_data;
                  mv_in = mv_ff + CntW'(1);
                  rd_addr = IdxW'(mv_ff + CntW'(2));
                  state_in = S_SHDN;
                  state_in = S_SHDNW;
               end else begin
                  count_in = count_ff - CntW'(1);
                  rd_addr = IdxW'(idx_ff + CntW'(1));
                  state_in = S_MERGE;
                  state_in = S_SHDNW;
                  mv_in = '1;
               end
               if (mv_ff == '1) begin
                  wr_en = 1'b0;
                  rd_addr = IdxW'(idx_ff + CntW'(1));
                  count_in = count_ff;
                  mv_in = mv_ff;
                  state_in = S_MERGE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff <= BaseReset;
         limit_ff <= LimitReset;
         count_ff <= CntW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         limit_ff <= limit_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      mv_ff <= mv_in;
      cmd_ff <= cmd_in;
      need_ff <= need_in;
      addr_ff <= addr_in;
      hit_ff <= hit_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff <= rsp_st_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CntW'(1) && count_ff <= CntW'(MaxSegments))
      else $error("segment count out of range");
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_st_ff <= ST_UNKNOWN)
      else $error("bad status");
   a_ok_zero_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_st_ff != ST_OK |-> rsp_addr_ff == 32'd0)
      else $error("failure with address");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=>
         rsp_valid_ff && $stable(rsp_addr_ff) && $stable(rsp_st_ff))
      else $error("result beat changed while waiting");
endmodule
`default_nettype wire
